// ----- src/refcounted_slot_id_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Slot id allocator: assertion macros
// Shared concurrent assertion forms, clocked and disabled by the block reset.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_SLOT_ID_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_SLOT_ID_ALLOCATOR_DEFINES_SVH

// Consequent checked at the same edge as the antecedent
`define RSID_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked at the edge after the antecedent
`define RSID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rsid_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot id allocator package
// Field widths, operation and register codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package rsid_pkg;

	localparam int MODE_W      = 2;
	localparam int ID_W        = 10;
	localparam int NEXT_W      = 11;
	localparam int FIXED_W     = 10;
	localparam int RSV_W       = 11;
	localparam int CNT_OUT_W   = 16;
	localparam int WORD_W      = 32;
	localparam int BIT_W       = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 11;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_USE     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DISCARD = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_START = 1'd1;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic fail;
		logic take;
		logic rd;
		logic rmw;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic in_alloc;
		logic hit;
		logic exhausted;
	} sts_t;

	// Lowest clear bit of a busy word: {found, index}
	function automatic logic [BIT_W:0] find_free(input logic [WORD_W-1:0] busy);
		logic [BIT_W:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!busy[i]) begin
				r = {1'b1, BIT_W'(i)};
			end
		end
		return r;
	endfunction

endpackage

// ----- src/refcounted_slot_id_allocator.sv -----
// Sequence: allocate scans from acceptance, at most SLOTS/32 words less the reserved words,
//   then takes the free slot found or reports a full result; use and discard read the slot,
//   then update it; a finished result is held until a previous one is taken on m_tready.
// Throughput: one transaction at a time, the next accepted the cycle after the result is
//   loaded; the bitmap memory read port scans one word a cycle.
// Reset: arst_n clears control state, then a clearing pass over every slot zeroes the
//   bitmap and count memories while s_tready stays low; configuration writes still apply.
// ----------------------------------------------------------------------------
// Reference-counted slot id allocator
// Bitmap allocator with saturating per-slot reference counts, stream interface.
// ----------------------------------------------------------------------------
module refcounted_slot_id_allocator #(
	parameter int SLOTS      = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// mode[1:0], slot_id[11:2], zero fill
	input  logic [rsid_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// result_id[9:0], full_res[10], released[11], rejected[12], count_after[28:13], zero fill
	output logic [rsid_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                               cfg_we,
	input  logic [rsid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsid_pkg::CFG_DATA_W-1:0]    cfg_data
);

	rsid_pkg::cmd_t cmd;
	rsid_pkg::sts_t sts;

	rsid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsid_dp #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- src/rsid_ctrl.sv -----
// ----------------------------------------------------------------------------
// Slot id allocator controller
// Sequences the clearing pass, bitmap scan, read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
`include "refcounted_slot_id_allocator_defines.svh"

module rsid_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  rsid_pkg::sts_t sts,
	output rsid_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_TAKE  = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_RMW   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = sts.in_alloc ? ST_SCAN : ST_RD;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = ST_TAKE;
				end else if (sts.exhausted) begin
					cmd.fail = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_TAKE: begin
				cmd.take = 1'b1;
				state_d  = ST_DONE;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_RMW;
			end
			ST_RMW: begin
				cmd.rmw = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold the result until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`RSID_ASSERT_SAME(a_take_follows_hit, clk, arst_n, state_q == ST_TAKE, $past(sts.hit), "take without a scan hit")
	`RSID_ASSERT_NEXT(a_accept_starts_op, clk, arst_n, s_tvalid && s_tready, state_q == ST_SCAN || state_q == ST_RD, "accepted transaction did not start an operation")
	`RSID_ASSERT_SAME(a_no_result_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || m_tready, "pending result overwritten")

endmodule

// ----- src/rsid_dp.sv -----
// ----------------------------------------------------------------------------
// Slot id allocator datapath
// Used bitmap and count memories, scan pipeline, update logic and result regs.
// ----------------------------------------------------------------------------
module rsid_dp #(
	parameter int SLOTS      = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [rsid_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic [rsid_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                               cfg_we,
	input  logic [rsid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsid_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  rsid_pkg::cmd_t                     cmd,
	output rsid_pkg::sts_t                     sts
);

	localparam int WORDS  = SLOTS / 32;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int RW     = WA_W + 1;
	localparam int CW     = (SLOT_W + 1 > rsid_pkg::NEXT_W) ? SLOT_W + 1 : rsid_pkg::NEXT_W;
	localparam int FXW    = (WA_W > rsid_pkg::FIXED_W - rsid_pkg::BIT_W) ?
		WA_W : rsid_pkg::FIXED_W - rsid_pkg::BIT_W;
	localparam int WB     = rsid_pkg::WORD_W;
	localparam int BW     = rsid_pkg::BIT_W;
	localparam int PAD_W  = rsid_pkg::OUT_TDATA_W - rsid_pkg::ID_W - 3 - rsid_pkg::CNT_OUT_W;

	// Memories
	logic [WB-1:0]         used_mem [WORDS];
	logic [COUNT_BITS-1:0] cnt_mem  [SLOTS];

	// Configuration and pointer
	logic [rsid_pkg::FIXED_W-1:0] fixed_q;
	logic [rsid_pkg::RSV_W-1:0]   reserved_q;
	logic [rsid_pkg::NEXT_W-1:0]  next_id_q;

	// Operation
	logic [rsid_pkg::MODE_W-1:0] op_mode_q;
	logic [rsid_pkg::ID_W-1:0]   op_id_q;

	// Clearing pass
	logic [SLOT_W-1:0] clr_q;

	// Scan
	logic [WA_W-1:0] addr_q;
	logic [RW-1:0]   rem_q;
	logic            first_q;
	logic            try_ok_q;
	logic [WA_W-1:0] addr_s1;
	logic            first_s1;
	logic            rd_vld_s1;
	logic [WB-1:0]   used_rd_s1;
	logic [COUNT_BITS-1:0] cnt_rd_s1;
	logic [WB-1:0]   hit_word_q;
	logic [WA_W-1:0] hit_addr_q;
	logic [SLOT_W-1:0] hit_id_q;

	// Results
	logic [rsid_pkg::ID_W-1:0]      res_id_q;
	logic                           res_full_q;
	logic                           res_rel_q;
	logic                           res_rej_q;
	logic [rsid_pkg::CNT_OUT_W-1:0] res_cnt_q;
	logic [rsid_pkg::OUT_TDATA_W-1:0] out_data_q;

	// Combinational
	logic [CW-1:0]   rsv_raw;
	logic [CW-1:0]   rsv;
	logic [CW-1:0]   rw;
	logic [CW-1:0]   nid_c;
	logic            try_ok;
	logic [WA_W-1:0] ini;
	logic            issue;
	logic [RW-1:0]   a_nx;
	logic [FXW-1:0]  fx_word;
	logic [FXW-1:0]  a_ext;
	logic [WB-1:0]   fix_mask;
	logic [WB-1:0]   busy;
	logic [BW:0]     ff;
	logic [BW-1:0]   nid_bit;
	logic            try_hit;
	logic [BW-1:0]   bit_sel;
	logic            scan_hit;

	logic [WA_W-1:0]       op_word;
	logic [SLOT_W-1:0]     op_slot;
	logic [CW-1:0]         id_c;
	logic                  in_pool;
	logic                  slot_busy;
	logic                  cnt_max;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic                  rmw_cnt_we;
	logic [COUNT_BITS-1:0] rmw_cnt_wd;
	logic                  rmw_used_we;
	logic                  rmw_rel;
	logic                  rmw_rej;
	logic [COUNT_BITS-1:0] rmw_res_cnt;

	logic                  used_we;
	logic [WA_W-1:0]       used_waddr;
	logic [WB-1:0]         used_wdata;
	logic [WA_W-1:0]       used_raddr;
	logic                  cnt_we;
	logic [SLOT_W-1:0]     cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;

	// Reserved boundary, rounded down to a word and clamped to the pool
	always_comb begin
		rsv_raw = CW'(reserved_q & ~rsid_pkg::RSV_W'(WB - 1));
		rsv     = (rsv_raw > CW'(SLOTS)) ? CW'(SLOTS) : rsv_raw;
		rw      = rsv >> BW;
		nid_c   = CW'(next_id_q);
		try_ok  = (nid_c < CW'(SLOTS)) && (nid_c >= rsv);
		ini     = try_ok ? WA_W'(nid_c >> BW) : WA_W'(rw);
	end

	// Scan: one word issued per cycle, evaluated in the cycle after its issue
	assign issue = cmd.scan && (rem_q != '0);
	assign a_nx  = RW'(addr_q) + RW'(1);

	always_comb begin
		fx_word = FXW'(fixed_q[rsid_pkg::FIXED_W-1:BW]);
		a_ext   = FXW'(addr_s1);
		if (a_ext < fx_word) begin
			fix_mask = '1;
		end else if (a_ext == fx_word) begin
			fix_mask = (WB'(1) << fixed_q[BW-1:0]) - WB'(1);
		end else begin
			fix_mask = '0;
		end
		busy     = used_rd_s1 | fix_mask;
		ff       = rsid_pkg::find_free(busy);
		nid_bit  = next_id_q[BW-1:0];
		try_hit  = first_s1 && try_ok_q && !busy[nid_bit];
		bit_sel  = try_hit ? nid_bit : ff[BW-1:0];
		scan_hit = cmd.scan && rd_vld_s1 && ff[BW];
	end

	assign sts.clear_last = (clr_q == SLOT_W'(SLOTS - 1));
	assign sts.in_alloc   = (s_tdata[rsid_pkg::MODE_W-1:0] == rsid_pkg::MODE_ALLOC);
	assign sts.hit        = scan_hit;
	assign sts.exhausted  = (rem_q == '0) && !rd_vld_s1;

	// Use / discard update
	always_comb begin
		op_word   = WA_W'(op_id_q >> BW);
		op_slot   = SLOT_W'(op_id_q);
		id_c      = CW'(op_id_q);
		in_pool   = id_c < CW'(SLOTS);
		slot_busy = used_rd_s1[op_id_q[BW-1:0]] || (op_id_q < fixed_q);
		cnt_max   = (cnt_rd_s1 == '1);
		cnt_inc   = cnt_rd_s1 + COUNT_BITS'(1);
		cnt_dec   = cnt_rd_s1 - COUNT_BITS'(1);

		rmw_cnt_we  = 1'b0;
		rmw_cnt_wd  = cnt_rd_s1;
		rmw_used_we = 1'b0;
		rmw_rel     = 1'b0;
		rmw_rej     = 1'b0;
		rmw_res_cnt = in_pool ? cnt_rd_s1 : '0;
		case (op_mode_q)
			rsid_pkg::MODE_USE: begin
				if (in_pool && !cnt_max) begin
					rmw_cnt_we  = 1'b1;
					rmw_cnt_wd  = cnt_inc;
					rmw_res_cnt = cnt_inc;
				end
			end
			rsid_pkg::MODE_DISCARD: begin
				if (!in_pool || !slot_busy || (cnt_rd_s1 == '0)) begin
					rmw_rej = 1'b1;
				end else begin
					rmw_cnt_we  = 1'b1;
					rmw_cnt_wd  = cnt_dec;
					rmw_res_cnt = cnt_dec;
					// free at zero unless the slot is reserved or fixed
					if ((cnt_dec == '0) && (id_c >= rsv) && (op_id_q >= fixed_q)) begin
						rmw_used_we = 1'b1;
						rmw_rel     = 1'b1;
					end
				end
			end
			default: begin
				rmw_res_cnt = in_pool ? cnt_rd_s1 : '0;
			end
		endcase
	end

	// Memory port selection
	always_comb begin
		used_raddr = cmd.scan ? addr_q : op_word;
		used_we    = 1'b0;
		used_waddr = op_word;
		used_wdata = used_rd_s1 & ~(WB'(1) << op_id_q[BW-1:0]);
		cnt_we     = 1'b0;
		cnt_waddr  = op_slot;
		cnt_wdata  = rmw_cnt_wd;
		if (cmd.clear) begin
			used_we    = 1'b1;
			used_waddr = clr_q[WA_W-1:0];
			used_wdata = '0;
			cnt_we     = 1'b1;
			cnt_waddr  = clr_q;
			cnt_wdata  = '0;
		end else if (cmd.take) begin
			used_we    = 1'b1;
			used_waddr = hit_addr_q;
			used_wdata = hit_word_q;
			cnt_we     = 1'b1;
			cnt_waddr  = hit_id_q;
			cnt_wdata  = '0;
		end else if (cmd.rmw) begin
			used_we = rmw_used_we;
			cnt_we  = rmw_cnt_we;
		end
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_waddr] <= used_wdata;
		end
		used_rd_s1 <= used_mem[used_raddr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_s1 <= cnt_mem[op_slot];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q    <= '0;
			reserved_q <= '0;
			next_id_q  <= '0;
			clr_q      <= '0;
			rem_q      <= '0;
			rd_vld_s1  <= 1'b0;
			first_q    <= 1'b0;
			try_ok_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rsid_pkg::CFG_FIXED_COUNT: begin
						fixed_q <= cfg_data[rsid_pkg::FIXED_W-1:0];
					end
					rsid_pkg::CFG_RESERVED_START: begin
						reserved_q <= cfg_data[rsid_pkg::RSV_W-1:0];
						next_id_q  <= cfg_data[rsid_pkg::NEXT_W-1:0];
					end
					default: begin
						fixed_q <= fixed_q;
					end
				endcase
			end
			if (cmd.clear) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (cmd.load) begin
				rem_q     <= RW'(CW'(WORDS) - rw);
				rd_vld_s1 <= 1'b0;
				first_q   <= 1'b1;
				try_ok_q  <= try_ok;
			end else if (cmd.scan) begin
				rd_vld_s1 <= issue;
				if (issue) begin
					rem_q   <= rem_q - RW'(1);
					first_q <= 1'b0;
				end
			end
			if (cmd.take) begin
				next_id_q <= rsid_pkg::NEXT_W'(CW'(hit_id_q) + CW'(1));
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_mode_q <= s_tdata[rsid_pkg::MODE_W-1:0];
			op_id_q   <= s_tdata[rsid_pkg::MODE_W +: rsid_pkg::ID_W];
			addr_q    <= ini;
		end else if (issue) begin
			// wrap from the end of the pool back to the word at the reserved boundary
			addr_q <= (a_nx == RW'(WORDS)) ? WA_W'(rw) : WA_W'(a_nx);
		end
		if (issue) begin
			addr_s1  <= addr_q;
			first_s1 <= first_q;
		end
		if (scan_hit) begin
			hit_word_q <= used_rd_s1 | (WB'(1) << bit_sel);
			hit_addr_q <= addr_s1;
			hit_id_q   <= SLOT_W'({addr_s1, bit_sel});
		end
		if (cmd.take) begin
			res_id_q   <= rsid_pkg::ID_W'(hit_id_q);
			res_full_q <= 1'b0;
			res_rel_q  <= 1'b0;
			res_rej_q  <= 1'b0;
			res_cnt_q  <= '0;
		end else if (cmd.fail) begin
			res_id_q   <= '0;
			res_full_q <= 1'b1;
			res_rel_q  <= 1'b0;
			res_rej_q  <= 1'b0;
			res_cnt_q  <= '0;
		end else if (cmd.rmw) begin
			res_id_q   <= op_id_q;
			res_full_q <= 1'b0;
			res_rel_q  <= rmw_rel;
			res_rej_q  <= rmw_rej;
			res_cnt_q  <= rsid_pkg::CNT_OUT_W'(rmw_res_cnt);
		end
		if (cmd.out_load) begin
			out_data_q <= {PAD_W'(0), res_cnt_q, res_rej_q, res_rel_q, res_full_q, res_id_q};
		end
	end

	assign m_tdata = out_data_q;

endmodule
